// ===== design/pfe_pkg.sv =====
// ----------------------------------------------------------------------------
// pfe_pkg
// Shared types and constants for the postfix expression evaluator.
// ----------------------------------------------------------------------------
package pfe_pkg;

  localparam int DEFAULT_STACK_DEPTH = 32;
  localparam int DEFAULT_VALUE_WIDTH = 32;
  localparam int CHAR_WIDTH          = 8;
  localparam int OUT_WIDTH           = 32;

  // ASCII codes that the evaluator reacts to.
  localparam logic [CHAR_WIDTH-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_WIDTH-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_WIDTH-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_WIDTH-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_WIDTH-1:0] CH_STAR  = 8'h2A;
  localparam logic [CHAR_WIDTH-1:0] CH_SLASH = 8'h2F;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_UNDERFLOW = 3'd1,
    ST_OVERFLOW  = 3'd2,
    ST_DIV_ZERO  = 3'd3,
    ST_EMPTY     = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_OPERATE,
    S_WAIT,
    S_FINISH
  } state_t;

  typedef enum logic [1:0] {
    CM_HOLD,
    CM_TAKE_UPPER,
    CM_TAKE_LOWER
  } cell_mode_t;

  typedef struct packed {
    logic start;
    logic div;
  } alu_req_t;

  typedef struct packed {
    logic [CHAR_WIDTH-1:0] char_code;
    logic                  last;
  } char_beat_t;

  typedef struct packed {
    logic signed [OUT_WIDTH-1:0] value;
    status_t                     status;
  } result_beat_t;

endpackage

// ===== design/pfe_stream_if.sv =====
// ----------------------------------------------------------------------------
// pfe_stream_if
// Valid/ready channel carrying one beat of a packed payload type.
// ----------------------------------------------------------------------------
interface pfe_stream_if #(
  parameter type beat_t = logic
);
  logic  valid;
  logic  ready;
  beat_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== design/pfe_cell.sv =====
// ----------------------------------------------------------------------------
// pfe_cell
// One entry of the shifting value stack. It holds its value, takes the value
// of the entry above it on a push, or of the entry below it on a pop.
// ----------------------------------------------------------------------------
module pfe_cell #(
  parameter int VALUE_WIDTH = pfe_pkg::DEFAULT_VALUE_WIDTH
) (
  input  logic                   clk,
  input  pfe_pkg::cell_mode_t    mode,
  input  logic [VALUE_WIDTH-1:0] from_upper,
  input  logic [VALUE_WIDTH-1:0] from_lower,
  output logic [VALUE_WIDTH-1:0] value
);
  import pfe_pkg::*;

  always_ff @(posedge clk) begin
    unique case (mode)
      CM_TAKE_UPPER: value <= from_upper;
      CM_TAKE_LOWER: value <= from_lower;
      default:       value <= value;
    endcase
  end

endmodule

// ===== design/pfe_alu.sv =====
// ----------------------------------------------------------------------------
// pfe_alu
// Iterative multiply and signed divide, one bit per cycle. Multiply keeps the
// low word of the product; divide truncates toward zero.
// ----------------------------------------------------------------------------
module pfe_alu #(
  parameter int VALUE_WIDTH = pfe_pkg::DEFAULT_VALUE_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  pfe_pkg::alu_req_t      req,
  input  logic [VALUE_WIDTH-1:0] lhs,
  input  logic [VALUE_WIDTH-1:0] rhs,
  output logic                   done,
  output logic [VALUE_WIDTH-1:0] result
);
  import pfe_pkg::*;

  localparam int W  = VALUE_WIDTH;
  localparam int CW = $clog2(W);

  logic          busy;
  logic          div_mode;
  logic          neg;
  logic [W-1:0]  a;
  logic [W-1:0]  b;
  logic [W-1:0]  acc;
  logic [CW-1:0] step;

  logic [W-1:0]  lhs_mag;
  logic [W-1:0]  rhs_mag;
  logic [W-1:0]  acc_mul;
  logic [W:0]    rem_sh;
  logic [W:0]    diff;
  logic          ge;
  logic [W-1:0]  acc_div;
  logic [W-1:0]  a_div;
  logic [W-1:0]  a_step;
  logic [W-1:0]  b_step;
  logic [W-1:0]  acc_step;

  always_comb begin
    lhs_mag = lhs[W-1] ? (~lhs + W'(1)) : lhs;
    rhs_mag = rhs[W-1] ? (~rhs + W'(1)) : rhs;

    // Shift-add multiply step.
    acc_mul = b[0] ? (acc + a) : acc;

    // Restoring divide step: the dividend shifts out of a, quotient bits in.
    rem_sh  = {acc, a[W-1]};
    diff    = rem_sh - {1'b0, b};
    ge      = ~diff[W];
    acc_div = ge ? diff[W-1:0] : rem_sh[W-1:0];
    a_div   = {a[W-2:0], ge};

    if (div_mode) begin
      a_step   = a_div;
      b_step   = b;
      acc_step = acc_div;
    end else begin
      a_step   = a << 1;
      b_step   = b >> 1;
      acc_step = acc_mul;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && step == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      div_mode <= req.div;
      neg      <= req.div & (lhs[W-1] ^ rhs[W-1]);
      a        <= req.div ? lhs_mag : lhs;
      b        <= req.div ? rhs_mag : rhs;
      acc      <= '0;
      step     <= CW'(W - 1);
    end else if (busy) begin
      a    <= a_step;
      b    <= b_step;
      acc  <= acc_step;
      step <= step - CW'(1);
      if (step == '0) begin
        if (div_mode) begin
          result <= neg ? (~a_div + W'(1)) : a_div;
        end else begin
          result <= acc_mul;
        end
      end
    end
  end

endmodule

// ===== design/postfix_expression_evaluator.sv =====
// ----------------------------------------------------------------------------
// postfix_expression_evaluator
// Evaluates a postfix expression that arrives one character per beat and
// returns the top of the value stack and a status on the closing character.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Payload                       Beat
//   chars     sink       char_code[7:0], last          one character
//   result    source     value[31:0] signed, status    one per expression
//
// Steps: a digit, a blank or another skipped character is taken in the idle
// state, as is a non-digit that closes a number. Plus and minus pass from
// idle to the operate state, which does the stack operation. Times and divide
// go on from the operate state to a wait for the bit-serial multiply/divide
// unit. An operator that finds fewer than two entries, or a divide by zero,
// stops in the operate state. The closing character leads to a finish state
// in which the result register is loaded and the state clears.
// Reset: rst is synchronous; it empties the stack count, the number being
// built and the error code. The stack entries themselves are not cleared.
// Stalls: a result waits in its output register until it is taken; the chars
// channel is held off while the block is busy or the full register is not taken.
//
module postfix_expression_evaluator #(
  parameter int STACK_DEPTH = pfe_pkg::DEFAULT_STACK_DEPTH,
  parameter int VALUE_WIDTH = pfe_pkg::DEFAULT_VALUE_WIDTH
) (
  input  logic         clk,
  input  logic         rst,
  pfe_stream_if.sink   chars,
  pfe_stream_if.source result
);
  import pfe_pkg::*;

  localparam int W    = VALUE_WIDTH;
  localparam int CNTW = $clog2(STACK_DEPTH + 1);

  // Control state.
  state_t          state;
  state_t          state_next;
  logic [CNTW-1:0] count;
  logic [CNTW-1:0] count_next;
  logic [W-1:0]    acc;
  logic [W-1:0]    acc_next;
  logic            in_number;
  logic            in_number_next;
  status_t         err;
  status_t         err_next;
  logic            out_valid;

  // Beat held while an operator is worked on.
  logic [CHAR_WIDTH-1:0] op_q;
  logic                  last_q;

  // Result register.
  logic signed [OUT_WIDTH-1:0] out_value;
  status_t                     out_status;

  // Stack control.
  logic         push;
  logic         replace;
  logic [W-1:0] new_top;
  logic         load_out;
  alu_req_t     alu_req;
  logic         alu_done;
  logic [W-1:0] alu_result;

  logic [W-1:0]        stack_val [STACK_DEPTH];
  cell_mode_t          cell_mode [STACK_DEPTH];
  logic signed [W-1:0] top_s;

  logic                  accept;
  logic [CHAR_WIDTH-1:0] c;
  logic                  is_digit;
  logic                  is_op;
  logic [W-1:0]          acc_dec;

  assign chars.ready = (state == S_IDLE) && (!out_valid || result.ready);
  assign accept      = chars.valid && chars.ready;
  assign c           = chars.data.char_code;
  assign is_digit    = (c >= CH_ZERO) && (c <= CH_NINE);
  assign is_op       = (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR) || (c == CH_SLASH);
  assign acc_dec     = (acc << 3) + (acc << 1) + W'(c - CH_ZERO);
  assign top_s       = stack_val[0];

  // The stack is a row of cells. Entry 0 is the top. A push shifts every
  // entry one place down; a binary operation shifts every entry below the top
  // one place up, and the top takes the result.
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [W-1:0] upper;
    logic [W-1:0] lower;

    if (i == 0) begin : g_head
      assign upper = new_top;
    end else begin : g_body
      assign upper = stack_val[i-1];
    end

    if (i == STACK_DEPTH - 1) begin : g_tail
      assign lower = stack_val[i];
    end else begin : g_inner
      assign lower = stack_val[i+1];
    end

    always_comb begin
      if (push || (replace && i == 0)) begin
        cell_mode[i] = CM_TAKE_UPPER;
      end else if (replace) begin
        cell_mode[i] = CM_TAKE_LOWER;
      end else begin
        cell_mode[i] = CM_HOLD;
      end
    end

    pfe_cell #(
      .VALUE_WIDTH(W)
    ) u_cell (
      .clk       (clk),
      .mode      (cell_mode[i]),
      .from_upper(upper),
      .from_lower(lower),
      .value     (stack_val[i])
    );
  end

  pfe_alu #(
    .VALUE_WIDTH(W)
  ) u_alu (
    .clk   (clk),
    .rst   (rst),
    .req   (alu_req),
    .lhs   (stack_val[1]),
    .rhs   (stack_val[0]),
    .done  (alu_done),
    .result(alu_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      acc       <= '0;
      in_number <= 1'b0;
      err       <= ST_OK;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      acc       <= acc_next;
      in_number <= in_number_next;
      err       <= err_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q   <= c;
      last_q <= chars.data.last;
    end
    if (load_out) begin
      if (err != ST_OK) begin
        out_value  <= '0;
        out_status <= err;
      end else if (count == '0) begin
        out_value  <= '0;
        out_status <= ST_EMPTY;
      end else begin
        out_value  <= OUT_WIDTH'(top_s);
        out_status <= ST_OK;
      end
    end
  end

  assign result.valid       = out_valid;
  assign result.data.value  = out_value;
  assign result.data.status = out_status;

  always_comb begin
    state_next     = state;
    count_next     = count;
    acc_next       = acc;
    in_number_next = in_number;
    err_next       = err;
    push           = 1'b0;
    replace        = 1'b0;
    new_top        = acc;
    load_out       = 1'b0;
    alu_req        = '0;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (err != ST_OK) begin
            // After an error only the closing character matters.
            state_next = chars.data.last ? S_FINISH : S_IDLE;
          end else if (is_digit) begin
            acc_next       = acc_dec;
            in_number_next = 1'b1;
            if (chars.data.last) begin
              // The closing digit ends the number in the same cycle.
              new_top = acc_dec;
              if (count == CNTW'(STACK_DEPTH)) begin
                err_next = ST_OVERFLOW;
              end else begin
                push       = 1'b1;
                count_next = count + CNTW'(1);
              end
              state_next = S_FINISH;
            end
          end else begin
            // Any non-digit closes a pending number.
            if (in_number) begin
              acc_next       = '0;
              in_number_next = 1'b0;
              if (count == CNTW'(STACK_DEPTH)) begin
                err_next = ST_OVERFLOW;
              end else begin
                push       = 1'b1;
                count_next = count + CNTW'(1);
              end
            end
            if (is_op && !(in_number && count == CNTW'(STACK_DEPTH))) begin
              state_next = S_OPERATE;
            end else begin
              state_next = chars.data.last ? S_FINISH : S_IDLE;
            end
          end
        end
      end

      S_OPERATE: begin
        state_next = last_q ? S_FINISH : S_IDLE;
        if (count < CNTW'(2)) begin
          err_next = ST_UNDERFLOW;
        end else begin
          unique case (op_q)
            CH_PLUS: begin
              new_top    = stack_val[1] + stack_val[0];
              replace    = 1'b1;
              count_next = count - CNTW'(1);
            end
            CH_MINUS: begin
              new_top    = stack_val[1] - stack_val[0];
              replace    = 1'b1;
              count_next = count - CNTW'(1);
            end
            CH_STAR: begin
              alu_req.start = 1'b1;
              state_next    = S_WAIT;
            end
            default: begin
              if (stack_val[0] == '0) begin
                err_next = ST_DIV_ZERO;
              end else begin
                alu_req.start = 1'b1;
                alu_req.div   = 1'b1;
                state_next    = S_WAIT;
              end
            end
          endcase
        end
      end

      S_WAIT: begin
        if (alu_done) begin
          new_top    = alu_result;
          replace    = 1'b1;
          count_next = count - CNTW'(1);
          state_next = last_q ? S_FINISH : S_IDLE;
        end
      end

      S_FINISH: begin
        // Report, then return to the reset state for the next expression.
        load_out       = 1'b1;
        count_next     = '0;
        acc_next       = '0;
        in_number_next = 1'b0;
        err_next       = ST_OK;
        state_next     = S_IDLE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
